/* sv/nsct_pkg.sv */
// Shared types, constants and helpers for the node status change tracker.
// No dependencies; every module of the block imports this package.
package nsct_pkg;

  localparam int NODE_LIMIT   = 16;
  localparam int NUM_NODES    = NODE_LIMIT - 1;
  localparam int NODE_W       = $clog2(NODE_LIMIT);
  localparam int IDX_W        = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
  localparam int NODE_FIELD_W = 4;
  localparam int MASK_W       = 15;
  localparam int MASK_IW      = $clog2(MASK_W);

  localparam logic [7:0] LINK_MIN_LEN      = 8'd1;
  localparam logic [7:0] FW_STATUS_MIN_LEN = 8'd9;

  // input item kinds
  localparam logic [2:0] KIND_LINK   = 3'd0;
  localparam logic [2:0] KIND_FW     = 3'd1;
  localparam logic [2:0] KIND_POLL   = 3'd2;
  localparam logic [2:0] KIND_KEEP   = 3'd3;
  localparam logic [2:0] KIND_RESEND = 3'd4;
  localparam logic [2:0] KIND_FETCH  = 3'd5;

  // result item kinds
  localparam logic [1:0] OUT_LINK_GET = 2'd0;
  localparam logic [1:0] OUT_FW_GET   = 2'd1;
  localparam logic [1:0] OUT_STATUS   = 2'd2;
  localparam logic [1:0] OUT_NONE     = 2'd3;

  typedef struct packed {
    logic        seen_link;
    logic        seen_fw;
    logic        link_up;
    logic [7:0]  boot;
    logic [15:0] version;
    logic        due;
  } entry_t;

  typedef struct packed {
    logic             wr_en;
    logic             clr_en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } tbl_req_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic [NODE_FIELD_W-1:0] node;
    logic                    link;
    logic [7:0]              boot;
    logic [15:0]             version;
    logic                    last;
  } res_t;

  // Mask bit of node n; nodes past the mask width count as clear.
  function automatic logic mask_bit(input logic [MASK_W-1:0] mask,
                                    input logic [NODE_W-1:0] n);
    logic [MASK_IW-1:0] bi;
    bi = MASK_IW'(int'(n) - 1);
    if (n == '0 || int'(n) > MASK_W) begin
      return 1'b0;
    end
    return mask[bi];
  endfunction

  // Round-robin successor: 1 .. NUM_NODES, wrapping to 1.
  function automatic logic [NODE_W-1:0] next_node(input logic [NODE_W-1:0] p);
    if (int'(p) >= NUM_NODES) begin
      return NODE_W'(int'(p) - NUM_NODES + 1);
    end
    return NODE_W'(int'(p) + 1);
  endfunction

  // Table index of a node; out-of-range nodes map to entry 0.
  function automatic logic [IDX_W-1:0] node_idx(input logic [NODE_W-1:0] n);
    if (n == '0 || int'(n) > NUM_NODES) begin
      return '0;
    end
    return IDX_W'(int'(n) - 1);
  endfunction

endpackage

/* sv/nsct_table.sv */
// Node table: one entry per bus node, single read port with registered data.
// Per-entry valid bits make reset and clears immediate. Uses nsct_pkg.
module nsct_table import nsct_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_entry,
  input  tbl_req_t         req
);

  entry_t                 mem [NUM_NODES];
  logic [NUM_NODES-1:0]   valid_r;
  entry_t                 rd_data_r;
  logic                   rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.addr] <= 1'b1;
      end else if (req.clr_en) begin
        valid_r[req.addr] <= 1'b0;
      end
      rd_vld_r <= valid_r[rd_addr];
    end
  end

  // an entry that was never written or was cleared reads as all zero
  assign rd_entry = rd_vld_r ? rd_data_r : '0;

endmodule

/* sv/nsct_seq.sv */
// Sequencer: decodes an item and walks the node table one entry per cycle
// through a shared compare/update step. Uses nsct_pkg.
module nsct_seq import nsct_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [2:0]              in_kind,
  input  logic [NODE_FIELD_W-1:0] in_node,
  input  logic [7:0]              in_payload_len,
  input  logic [7:0]              in_first_byte,
  input  logic [7:0]              in_boot_state,
  input  logic [15:0]             in_fw_version,
  input  logic [MASK_W-1:0]       in_active_mask,
  input  logic [MASK_W-1:0]       in_controller_mask,
  input  logic [7:0]              status_op,
  output logic [IDX_W-1:0]        rd_addr,
  input  entry_t                  rd_entry,
  output tbl_req_t                tbl_req,
  output logic                    res_valid,
  output res_t                    res,
  input  logic                    res_ready
);

  typedef enum logic [1:0] {S_IDLE, S_RPT, S_SCAN, S_EMIT} state_t;

  state_t            state_r, state_nxt;
  logic [2:0]        kind_r, kind_nxt;
  logic [NODE_W-1:0] node_r, node_nxt;
  logic              up_r, up_nxt;
  logic [7:0]        boot_r, boot_nxt;
  logic [15:0]       ver_r, ver_nxt;
  logic [MASK_W-1:0] act_r, act_nxt;
  logic [MASK_W-1:0] ctl_r, ctl_nxt;
  logic [NODE_W-1:0] ptr_r, ptr_nxt;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  logic [NODE_W-1:0] cursor_r, cursor_nxt;
  res_t              res_r, res_nxt;

  logic              accept;
  logic [NODE_W-1:0] in_node_w;
  logic              node_ok;
  logic              rpt_ok;
  logic              known;
  logic              last_step;
  entry_t            upd;

  assign accept    = in_valid && (state_r == S_IDLE);
  assign in_stall  = (state_r != S_IDLE);
  assign in_node_w = NODE_W'(in_node);
  assign node_ok   = (in_node != '0) && (int'(in_node) < NODE_LIMIT)
                     && mask_bit(in_controller_mask, in_node_w);
  assign known     = rd_entry.seen_link && rd_entry.seen_fw;
  assign last_step = (cnt_r == IDX_W'(NUM_NODES - 1));
  assign res_valid = (state_r == S_EMIT);
  assign res       = res_r;

  always_comb begin
    rpt_ok = 1'b0;
    case (in_kind)
      KIND_LINK: rpt_ok = node_ok && (in_payload_len >= LINK_MIN_LEN);
      KIND_FW:   rpt_ok = node_ok && (in_payload_len >= FW_STATUS_MIN_LEN)
                          && (in_first_byte == status_op);
      default:   rpt_ok = 1'b0;
    endcase
  end

  // report update of the entry just read
  always_comb begin
    upd = rd_entry;
    if (kind_r == KIND_LINK) begin
      upd.due       = rd_entry.due || !rd_entry.seen_link || (up_r != rd_entry.link_up);
      upd.link_up   = up_r;
      upd.seen_link = 1'b1;
    end else begin
      upd.due     = rd_entry.due || !rd_entry.seen_fw || (boot_r != rd_entry.boot)
                    || (ver_r != rd_entry.version);
      upd.boot    = boot_r;
      upd.version = ver_r;
      upd.seen_fw = 1'b1;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    kind_nxt   = kind_r;
    node_nxt   = node_r;
    up_nxt     = up_r;
    boot_nxt   = boot_r;
    ver_nxt    = ver_r;
    act_nxt    = act_r;
    ctl_nxt    = ctl_r;
    ptr_nxt    = ptr_r;
    cnt_nxt    = cnt_r;
    cursor_nxt = cursor_r;
    res_nxt    = res_r;
    rd_addr    = '0;
    tbl_req    = '0;

    case (state_r)
      S_IDLE: begin
        case (in_kind)
          KIND_LINK, KIND_FW: rd_addr = node_idx(in_node_w);
          KIND_POLL:          rd_addr = node_idx(next_node(cursor_r));
          default:            rd_addr = '0;
        endcase
        if (accept) begin
          kind_nxt = in_kind;
          node_nxt = in_node_w;
          up_nxt   = (in_first_byte != 8'd0);
          boot_nxt = in_boot_state;
          ver_nxt  = in_fw_version;
          act_nxt  = in_active_mask;
          ctl_nxt  = in_controller_mask;
          cnt_nxt  = '0;
          case (in_kind)
            KIND_LINK, KIND_FW: begin
              if (rpt_ok) begin
                state_nxt = S_RPT;
              end
            end
            KIND_POLL: begin
              ptr_nxt   = next_node(cursor_r);
              state_nxt = S_SCAN;
            end
            KIND_KEEP, KIND_RESEND, KIND_FETCH: begin
              ptr_nxt   = NODE_W'(1);
              state_nxt = S_SCAN;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_RPT: begin
        rd_addr      = node_idx(node_r);
        tbl_req.wr_en = 1'b1;
        tbl_req.addr  = node_idx(node_r);
        tbl_req.data  = upd;
        state_nxt     = S_IDLE;
      end

      S_SCAN: begin
        // read the next candidate while this one is judged
        rd_addr      = node_idx(next_node(ptr_r));
        ptr_nxt      = next_node(ptr_r);
        cnt_nxt      = cnt_r + 1'b1;
        tbl_req.addr = node_idx(ptr_r);
        tbl_req.data = rd_entry;
        case (kind_r)
          KIND_KEEP: begin
            if (!mask_bit(act_r, ptr_r)) begin
              tbl_req.clr_en = 1'b1;
            end else if (known) begin
              tbl_req.wr_en    = 1'b1;
              tbl_req.data.due = 1'b1;
            end
            if (last_step) begin
              state_nxt = S_IDLE;
            end
          end
          KIND_RESEND: begin
            tbl_req.wr_en    = 1'b1;
            tbl_req.data.due = known;
            if (last_step) begin
              state_nxt = S_IDLE;
            end
          end
          KIND_FETCH: begin
            if (rd_entry.due && known) begin
              tbl_req.wr_en    = 1'b1;
              tbl_req.data.due = 1'b0;
              res_nxt.kind     = OUT_STATUS;
              res_nxt.node     = NODE_FIELD_W'(ptr_r);
              res_nxt.link     = rd_entry.link_up;
              res_nxt.boot     = rd_entry.boot;
              res_nxt.version  = rd_entry.version;
              res_nxt.last     = 1'b1;
              state_nxt        = S_EMIT;
            end else if (last_step) begin
              res_nxt      = '0;
              res_nxt.kind = OUT_NONE;
              res_nxt.last = 1'b1;
              state_nxt    = S_EMIT;
            end
          end
          KIND_POLL: begin
            if (mask_bit(act_r, ptr_r) && mask_bit(ctl_r, ptr_r)
                && !(rd_entry.seen_fw && rd_entry.boot != 8'd0)) begin
              cursor_nxt   = ptr_r;
              res_nxt      = '0;
              res_nxt.kind = OUT_LINK_GET;
              res_nxt.node = NODE_FIELD_W'(ptr_r);
              state_nxt    = S_EMIT;
            end else if (last_step) begin
              cursor_nxt = ptr_r;
              state_nxt  = S_IDLE;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end

      S_EMIT: begin
        if (res_ready) begin
          if (res_r.last) begin
            state_nxt = S_IDLE;
          end else begin
            // second request of a poll goes to the same node
            res_nxt.kind = OUT_FW_GET;
            res_nxt.last = 1'b1;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cursor_r <= '0;
      ptr_r    <= '0;
      cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      cursor_r <= cursor_nxt;
      ptr_r    <= ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    kind_r <= kind_nxt;
    node_r <= node_nxt;
    up_r   <= up_nxt;
    boot_r <= boot_nxt;
    ver_r  <= ver_nxt;
    act_r  <= act_nxt;
    ctl_r  <= ctl_nxt;
    res_r  <= res_nxt;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> int'(cnt_r) <= NUM_NODES - 1)
    else $error("scan count past table end");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cursor_r) <= NUM_NODES)
    else $error("poll cursor out of range");

  a_one_table_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(tbl_req.wr_en && tbl_req.clr_en))
    else $error("table write and clear in one cycle");

  a_poll_second: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT && res_ready && !res_r.last
    |=> state_r == S_EMIT && res_r.kind == OUT_FW_GET && res_r.last)
    else $error("firmware request does not follow link request");

endmodule

/* sv/node_status_change_tracker.sv */
// Top level of the node status change tracker: config register, output
// register and the sequencer/table pair. Uses nsct_pkg, nsct_seq, nsct_table.
//
//   port group   dir  handshake             payload
//   in_*         in   in_valid / in_stall   kind, node, report bytes, masks
//   out_*        out  out_valid / out_stall kind, node, stored status, last
//   APB          in   psel/penable/pready   status op code at byte address 0
//
// A report reads its entry and then writes it back; keepalive and resend walk
// all 15 entries at one entry per cycle; a fetch or a poll ends its walk early
// at its first match. The single table read port sets this pace.
// rst_n clears the table (per-entry valid bits), the poll cursor and the op
// code at once; no clearing pass is needed.
// in_stall is high while an item is in work; a result held by out_stall
// waits in the output register and holds the next result in the sequencer, which keeps in_stall high.
module node_status_change_tracker import nsct_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [2:0]              in_kind,
  input  logic [NODE_FIELD_W-1:0] in_node,
  input  logic [7:0]              in_payload_len,
  input  logic [7:0]              in_first_byte,
  input  logic [7:0]              in_boot_state,
  input  logic [15:0]             in_fw_version,
  input  logic [MASK_W-1:0]       in_active_mask,
  input  logic [MASK_W-1:0]       in_controller_mask,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_kind,
  output logic [NODE_FIELD_W-1:0] out_node,
  output logic                    out_link_state,
  output logic [7:0]              out_boot_value,
  output logic [15:0]             out_version_value,
  output logic                    out_last,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam logic REG_STATUS_OP = 1'b0;

  logic [7:0]       status_op_r;
  logic             out_valid_r;
  res_t             out_r;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_entry;
  tbl_req_t         tbl_req;
  logic             res_valid;
  res_t             res;
  logic             res_ready;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_STATUS_OP) ? {24'd0, status_op_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_op_r <= 8'd0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_STATUS_OP) begin
      status_op_r <= pwdata[7:0];
    end
  end

  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_r.kind;
  assign out_node          = out_r.node;
  assign out_link_state    = out_r.link;
  assign out_boot_value    = out_r.boot;
  assign out_version_value = out_r.version;
  assign out_last          = out_r.last;

  nsct_seq u_seq (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_node            (in_node),
    .in_payload_len     (in_payload_len),
    .in_first_byte      (in_first_byte),
    .in_boot_state      (in_boot_state),
    .in_fw_version      (in_fw_version),
    .in_active_mask     (in_active_mask),
    .in_controller_mask (in_controller_mask),
    .status_op          (status_op_r),
    .rd_addr            (rd_addr),
    .rd_entry           (rd_entry),
    .tbl_req            (tbl_req),
    .res_valid          (res_valid),
    .res                (res),
    .res_ready          (res_ready)
  );

  nsct_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .req      (tbl_req)
  );

endmodule
